@@ rtl/core/fsc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared widths, counts and the stage-advance bundle for the frustum culler.
// ----------------------------------------------------------------------------
package fsc_pkg;

    localparam int NUM_PLANES  = 6;
    localparam int REG_COUNT   = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int PLANE_W     = 64;

    localparam int NORM_W      = 12;
    localparam int OFS_W       = 28;
    localparam int NX_LSB      = 0;
    localparam int NY_LSB      = NX_LSB + NORM_W;
    localparam int NZ_LSB      = NY_LSB + NORM_W;
    localparam int OFS_LSB     = NZ_LSB + NORM_W;

    localparam int COORD_W     = 24;
    localparam int PROD_W      = COORD_W + NORM_W;
    localparam int DOT_W       = PROD_W + 2;
    localparam int DIFF_W      = OFS_W + 1;
    localparam int FRAC_SHIFT  = 10;
    localparam int LIM_W       = DIFF_W + FRAC_SHIFT;

    localparam int IN_TDATA_W  = 4 * COORD_W;
    localparam int OUT_TDATA_W = 8;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } fsc_adv_t;

endpackage
`default_nettype wire

@@ rtl/core/fsc_plane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fsc_plane
// Three-stage test of one sphere against one plane: products, dot and limit,
// then the strict compare that flags the sphere as outside.
// ----------------------------------------------------------------------------
module fsc_plane
    import fsc_pkg::*;
(
    input  wire logic                       clk,
    input  wire fsc_adv_t                   adv,
    input  wire logic [PLANE_W-1:0]         plane,
    input  wire logic signed [COORD_W-1:0]  center_x,
    input  wire logic signed [COORD_W-1:0]  center_y,
    input  wire logic signed [COORD_W-1:0]  center_z,
    input  wire logic [COORD_W-1:0]         radius,
    output logic                            outside
);

    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
    logic signed [OFS_W-1:0]  ofs;

    logic signed [PROD_W-1:0] prod_x_next;
    logic signed [PROD_W-1:0] prod_y_next;
    logic signed [PROD_W-1:0] prod_z_next;
    logic signed [DIFF_W-1:0] diff_next;
    logic signed [PROD_W-1:0] prod_x_reg;
    logic signed [PROD_W-1:0] prod_y_reg;
    logic signed [PROD_W-1:0] prod_z_reg;
    logic signed [DIFF_W-1:0] diff_reg;

    logic signed [DOT_W-1:0]  dot_next;
    logic signed [LIM_W-1:0]  lim_next;
    logic signed [DOT_W-1:0]  dot_reg;
    logic signed [LIM_W-1:0]  lim_reg;

    logic                     outside_next;
    logic                     outside_reg;

    assign nx  = plane[NX_LSB +: NORM_W];
    assign ny  = plane[NY_LSB +: NORM_W];
    assign nz  = plane[NZ_LSB +: NORM_W];
    assign ofs = plane[OFS_LSB +: OFS_W];

    always_comb
    begin
        prod_x_next  = PROD_W'(nx) * PROD_W'(center_x);
        prod_y_next  = PROD_W'(ny) * PROD_W'(center_y);
        prod_z_next  = PROD_W'(nz) * PROD_W'(center_z);
        diff_next    = DIFF_W'(ofs) - $signed({1'b0, radius});
        dot_next     = DOT_W'(prod_x_reg) + DOT_W'(prod_y_reg) + DOT_W'(prod_z_reg);
        lim_next     = {diff_reg, {FRAC_SHIFT{1'b0}}};
        outside_next = LIM_W'(dot_reg) < lim_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            prod_z_reg <= prod_z_next;
            diff_reg   <= diff_next;
        end
        if (adv.s2)
        begin
            dot_reg <= dot_next;
            lim_reg <= lim_next;
        end
        if (adv.s3)
        begin
            outside_reg <= outside_next;
        end
    end

    assign outside = outside_reg;

endmodule
`default_nettype wire

@@ rtl/core/frustum_sphere_cull.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frustum_sphere_cull
// Six-plane view-frustum culling of bounding spheres in fixed point.
// ----------------------------------------------------------------------------
// One sphere is taken per cycle while s_axis_tready is high.
// Every plane has its own three 12x24 multipliers, so all planes are tested in
// parallel through a four-stage pipeline (products, dot sum, compare, merge).
// Each stage advances when it is empty or the next one advances, so bubbles
// close up under back-pressure and s_axis_tready follows m_axis_tready only
// once all four stages hold a beat. Plane registers reset to zero, which
// makes every sphere visible; write them only while no beat is in flight.
// ----------------------------------------------------------------------------
module frustum_sphere_cull
    import fsc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // center_x [23:0], center_y [47:24], center_z [71:48], radius [95:72]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // visible [0], zero fill [7:1]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [PLANE_W-1:0]     cfg_data
);

    logic [PLANE_W-1:0]     plane_reg [REG_COUNT];

    logic                   v1_reg;
    logic                   v2_reg;
    logic                   v3_reg;
    logic                   v4_reg;
    logic                   v1_next;
    logic                   v2_next;
    logic                   v3_next;
    logic                   v4_next;
    logic                   rdy1;
    logic                   rdy2;
    logic                   rdy3;
    logic                   rdy4;
    fsc_adv_t               adv;
    logic                   adv4;

    logic [NUM_PLANES-1:0]  outside;
    logic                   visible_next;
    logic                   visible_reg;

    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [COORD_W-1:0]        radius;

    assign center_x = s_axis_tdata[0*COORD_W +: COORD_W];
    assign center_y = s_axis_tdata[1*COORD_W +: COORD_W];
    assign center_z = s_axis_tdata[2*COORD_W +: COORD_W];
    assign radius   = s_axis_tdata[3*COORD_W +: COORD_W];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                if (cfg_index == CFG_IDX_W'(i))
                begin
                    plane_reg[i] <= cfg_data;
                end
            end
        end
    end

    always_comb
    begin
        rdy4    = !v4_reg || m_axis_tready;
        rdy3    = !v3_reg || rdy4;
        rdy2    = !v2_reg || rdy3;
        rdy1    = !v1_reg || rdy2;
        adv.s1  = s_axis_tvalid && rdy1;
        adv.s2  = v1_reg && rdy2;
        adv.s3  = v2_reg && rdy3;
        adv4    = v3_reg && rdy4;
        v1_next = rdy1 ? s_axis_tvalid : v1_reg;
        v2_next = rdy2 ? v1_reg : v2_reg;
        v3_next = rdy3 ? v2_reg : v3_reg;
        v4_next = rdy4 ? v3_reg : v4_reg;
        visible_next = ~|outside;
    end

    assign s_axis_tready = rdy1;

    generate
        for (genvar p = 0; p < NUM_PLANES; p++)
        begin : g_plane
            logic [PLANE_W-1:0] plane_word;
            if (p < REG_COUNT)
            begin : g_reg
                assign plane_word = plane_reg[p];
            end
            else
            begin : g_zero
                assign plane_word = '0;
            end

            fsc_plane u_plane
            (
                .clk      (clk),
                .adv      (adv),
                .plane    (plane_word),
                .center_x (center_x),
                .center_y (center_y),
                .center_z (center_z),
                .radius   (radius),
                .outside  (outside[p])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            visible_reg <= visible_next;
        end
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, visible_reg};

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && !m_axis_tready |=> v4_reg)
        else $error("output beat dropped while stalled");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg && !v2_reg && !v3_reg && !v4_reg |-> s_axis_tready)
        else $error("empty pipeline refuses input");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !v3_reg |=> !m_axis_tvalid)
        else $error("output beat repeated");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && rdy4 |=> v4_reg)
        else $error("stage three beat lost");

endmodule
`default_nettype wire

@@ verif/tb_frustum_sphere_cull.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frustum_sphere_cull
// Self-checking bench for the sphere-vs-frustum culler. Plane registers are
// loaded through the config channel between phases. Spheres stream in with
// bursty gaps while the output side may stall. Each visible flag is checked in
// order against a fixed-point plane test kept inside the bench. Directed
// cases cover reset state, every register index, exact plane-boundary ties
// and field extremes. Random phases follow, with box-shaped, random and
// extreme plane sets and spheres aimed at the plane boundaries.
// ----------------------------------------------------------------------------
module tb_frustum_sphere_cull;
    import fsc_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int PHASE_COUNT  = 10;
    localparam int PHASE_ITEMS  = 200;
    localparam int TAIL_CYCLES  = 8;
    localparam int ONE_Q1_10    = 1 << FRAC_SHIFT;
    localparam int COORD_MAX    = (1 << (COORD_W - 1)) - 1;
    localparam int COORD_MIN    = -(1 << (COORD_W - 1));
    localparam int RADIUS_MAX   = (1 << COORD_W) - 1;
    localparam int NORM_MAX     = (1 << (NORM_W - 1)) - 1;
    localparam int NORM_MIN     = -(1 << (NORM_W - 1));
    localparam int OFS_MAX      = (1 << (OFS_W - 1)) - 1;
    localparam int OFS_MIN      = -(1 << (OFS_W - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEAR, REG_FAR, REG_LEFT, REG_RIGHT, REG_BOTTOM, REG_TOP,
        REG_SPARE6, REG_SPARE7
    } plane_reg_t;

    typedef enum {RX_STEADY, RX_CHOPPY, RX_BURSTY} rx_mode_t;
    typedef enum {FRUSTUM_BOX, FRUSTUM_RANDOM, FRUSTUM_EXTREME} frustum_kind_t;

    typedef struct packed {
        logic [COORD_W-1:0] radius;
        logic [COORD_W-1:0] cz;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cx;
    } sphere_t;

    typedef struct {
        plane_reg_t         idx;
        logic [PLANE_W-1:0] word;
    } plane_write_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [PLANE_W-1:0]     cfg_data;

    logic [PLANE_W-1:0]     plane_shadow [REG_COUNT];
    plane_write_t           staged_writes [$];
    bit                     expected_visible [$];
    bit                     visible_due;
    int                     error_count = 0;
    int                     idle_cycles = 0;
    int                     burst_left  = 0;
    int                     tx_gap_max  = 0;
    int                     rx_hold     = 0;
    rx_mode_t               rx_mode     = RX_STEADY;

    frustum_sphere_cull dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- model

    function automatic logic [PLANE_W-1:0] plane_word(input int nx, input int ny,
                                                      input int nz, input int ofs);
        logic [PLANE_W-1:0] w;
        w = '0;
        w[NX_LSB +: NORM_W]  = nx[NORM_W-1:0];
        w[NY_LSB +: NORM_W]  = ny[NORM_W-1:0];
        w[NZ_LSB +: NORM_W]  = nz[NORM_W-1:0];
        w[OFS_LSB +: OFS_W]  = ofs[OFS_W-1:0];
        return w;
    endfunction

    function automatic longint plane_offset(input logic [PLANE_W-1:0] w);
        return longint'($signed(w[OFS_LSB +: OFS_W]));
    endfunction

    function automatic longint plane_dot(input logic [PLANE_W-1:0] w, input sphere_t s);
        return longint'($signed(w[NX_LSB +: NORM_W])) * longint'($signed(s.cx))
             + longint'($signed(w[NY_LSB +: NORM_W])) * longint'($signed(s.cy))
             + longint'($signed(w[NZ_LSB +: NORM_W])) * longint'($signed(s.cz));
    endfunction

    function automatic bit predict_visible(input sphere_t s);
        longint limit;
        for (int p = 0; p < NUM_PLANES && p < REG_COUNT; p++)
        begin
            limit = (plane_offset(plane_shadow[p]) - longint'(s.radius)) * ONE_Q1_10;
            if (plane_dot(plane_shadow[p], s) < limit)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------ generators

    function automatic sphere_t make_sphere(input int cx, input int cy,
                                            input int cz, input int r);
        sphere_t s;
        s.cx     = COORD_W'(cx);
        s.cy     = COORD_W'(cy);
        s.cz     = COORD_W'(cz);
        s.radius = COORD_W'(r);
        return s;
    endfunction

    function automatic sphere_t random_sphere();
        sphere_t s;
        if ($urandom_range(0, 3) == 0)
        begin
            s.cx = COORD_W'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
            s.cy = COORD_W'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
            s.cz = COORD_W'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
        end
        else
        begin
            s.cx = COORD_W'($urandom);
            s.cy = COORD_W'($urandom);
            s.cz = COORD_W'($urandom);
        end
        case ($urandom_range(0, 3))
            0:       s.radius = COORD_W'($urandom);
            1:       s.radius = COORD_W'($urandom_range(0, 255));
            default: s.radius = COORD_W'($urandom_range(0, 1 << 20));
        endcase
        return s;
    endfunction

    // Aim the radius so one plane's limit lands on or just either side of the dot product.
    function automatic sphere_t boundary_sphere();
        sphere_t            s;
        logic [PLANE_W-1:0] w;
        longint             q;
        longint             r;
        s = random_sphere();
        if ($urandom_range(0, 1) == 1)
        begin
            s.cx[FRAC_SHIFT-1:0] = '0;
            s.cy[FRAC_SHIFT-1:0] = '0;
            s.cz[FRAC_SHIFT-1:0] = '0;
        end
        w = plane_shadow[$urandom_range(0, REG_COUNT - 1)];
        q = plane_dot(w, s) >>> FRAC_SHIFT;
        r = plane_offset(w) - q + longint'($urandom_range(0, 2)) - 1;
        if (r >= 0 && r <= RADIUS_MAX)
            s.radius = r[COORD_W-1:0];
        return s;
    endfunction

    function automatic logic [PLANE_W-1:0] random_plane();
        int ofs;
        case ($urandom_range(0, 2))
            0:       ofs = $urandom;
            1:       ofs = -int'($urandom_range(0, 1 << 24));
            default: ofs = int'($urandom_range(0, 1 << 16)) - (1 << 15);
        endcase
        return plane_word($urandom, $urandom, $urandom, ofs);
    endfunction

    function automatic void stage_plane(input plane_reg_t idx, input logic [PLANE_W-1:0] word);
        plane_write_t wr;
        wr.idx  = idx;
        wr.word = word;
        staged_writes.push_back(wr);
    endfunction

    // ------------------------------------------------------------ bus tasks

    task automatic drain_spheres();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_visible.size() != 0)
            @(negedge clk);
    endtask

    task automatic commit_planes();
        plane_write_t wr;
        drain_spheres();
        while (staged_writes.size() != 0)
        begin
            wr = staged_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= wr.idx;
            cfg_data  <= wr.word;
            do @(posedge clk); while (cfg_ready !== 1'b1);
            if (wr.idx < REG_COUNT)
                plane_shadow[wr.idx] = wr.word;
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sphere(input sphere_t s);
        int gap;
        if (burst_left == 0)
        begin
            gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        expected_visible.push_back(predict_visible(s));
        @(negedge clk);
    endtask

    // ----------------------------------------------------------------- tests

    task automatic test_after_reset();
        send_sphere(make_sphere(0, 0, 0, 0));
        send_sphere(make_sphere(COORD_MAX, COORD_MAX, COORD_MAX, 0));
        send_sphere(make_sphere(COORD_MIN, COORD_MIN, COORD_MIN, RADIUS_MAX));
        send_sphere(make_sphere(COORD_MIN, COORD_MAX, 0, 1));
    endtask

    task automatic test_register_index();
        logic [PLANE_W-1:0] cull_all;
        cull_all = plane_word(0, 0, 0, 1);
        for (int i = 0; i < REG_COUNT; i++)
        begin
            if (i > 0)
                stage_plane(plane_reg_t'(i - 1), '0);
            stage_plane(plane_reg_t'(i), cull_all);
            commit_planes();
            send_sphere(make_sphere(0, 0, 0, 0));
        end
        stage_plane(REG_TOP, '0);
        stage_plane(REG_SPARE6, cull_all);
        stage_plane(REG_SPARE7, cull_all);
        commit_planes();
        send_sphere(make_sphere(0, 0, 0, 0));
    endtask

    task automatic test_plane_boundaries();
        stage_plane(REG_NEAR, plane_word(ONE_Q1_10, 0, 0, 0));
        commit_planes();
        send_sphere(make_sphere(-256, 0, 0, 256));
        send_sphere(make_sphere(-256, 0, 0, 255));
        send_sphere(make_sphere(0, 0, 0, 0));
        send_sphere(make_sphere(-1, 0, 0, 0));

        stage_plane(REG_NEAR, plane_word(0, 0, 0, 5));
        commit_planes();
        send_sphere(make_sphere(COORD_MAX, COORD_MIN, 0, 5));
        send_sphere(make_sphere(COORD_MAX, COORD_MIN, 0, 4));

        stage_plane(REG_NEAR, plane_word(NORM_MAX, NORM_MAX, NORM_MAX, OFS_MAX));
        stage_plane(REG_FAR, plane_word(NORM_MIN, NORM_MIN, NORM_MIN, OFS_MIN));
        commit_planes();
        send_sphere(make_sphere(COORD_MAX, COORD_MAX, COORD_MAX, 0));
        send_sphere(make_sphere(COORD_MIN, COORD_MIN, COORD_MIN, RADIUS_MAX));
        send_sphere(make_sphere(COORD_MIN, COORD_MIN, COORD_MIN, 0));

        stage_plane(REG_NEAR, '1);
        stage_plane(REG_FAR, {1'b1, {(PLANE_W - 1){1'b0}}});
        commit_planes();
        send_sphere(make_sphere(0, 0, 0, 0));
        send_sphere(make_sphere(COORD_MAX, 1, -1, RADIUS_MAX));
    endtask

    task automatic test_random_frustums();
        int ext;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (frustum_kind_t'(phase % 3))
                FRUSTUM_BOX:
                begin
                    ext = $urandom_range(0, 1 << 23);
                    stage_plane(REG_NEAR,   plane_word(0, 0, ONE_Q1_10, -ext));
                    stage_plane(REG_FAR,    plane_word(0, 0, -ONE_Q1_10, -ext));
                    stage_plane(REG_LEFT,   plane_word(ONE_Q1_10, 0, 0, -ext));
                    stage_plane(REG_RIGHT,  plane_word(-ONE_Q1_10, 0, 0, -ext));
                    stage_plane(REG_BOTTOM, plane_word(0, ONE_Q1_10, 0, -ext));
                    stage_plane(REG_TOP,    plane_word(0, -ONE_Q1_10, 0, -ext));
                end
                FRUSTUM_RANDOM:
                    for (int i = 0; i < REG_COUNT; i++)
                        stage_plane(plane_reg_t'(i), random_plane());
                default:
                    for (int i = 0; i < REG_COUNT; i++)
                        case ($urandom_range(0, 4))
                            0: stage_plane(plane_reg_t'(i), '1);
                            1: stage_plane(plane_reg_t'(i), '0);
                            2: stage_plane(plane_reg_t'(i), {1'b1, {(PLANE_W - 1){1'b0}}});
                            3: stage_plane(plane_reg_t'(i),
                                           plane_word(NORM_MAX, NORM_MAX, NORM_MAX, OFS_MAX));
                            default: stage_plane(plane_reg_t'(i), random_plane());
                        endcase
            endcase
            if ($urandom_range(0, 1) == 1)
                stage_plane(plane_reg_t'($urandom_range(REG_COUNT, int'(REG_SPARE7))),
                            random_plane());
            commit_planes();

            tx_gap_max = (phase % 4 == 0) ? 0 : ((phase % 4 == 1) ? 2 : 10);
            rx_mode    = rx_mode_t'($urandom_range(0, 2));
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sphere(($urandom_range(0, 1) == 1) ? boundary_sphere() : random_sphere());
        end
    endtask

    // ------------------------------------------------------------- checking

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        begin
            if (expected_visible.size() == 0)
            begin
                $error("visible: beat with nothing expected, actual %0b", m_axis_tdata[0]);
                error_count++;
            end
            else
            begin
                visible_due = expected_visible.pop_front();
                if (m_axis_tdata[0] !== visible_due)
                begin
                    $error("visible: expected %0b, actual %0b", visible_due, m_axis_tdata[0]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1
            || (s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1)
            || (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            || (cfg_valid === 1'b1 && cfg_ready === 1'b1))
            idle_cycles = 0;
        else if (++idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_frustum_sphere_cull: FAIL");
            $finish;
        end
    end

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                case (rx_mode)
                    RX_CHOPPY: if ($urandom_range(0, 2) == 0) rx_hold = $urandom_range(1, 3);
                    RX_BURSTY: if ($urandom_range(0, 15) == 0) rx_hold = $urandom_range(4, 24);
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------- sequence

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        for (int i = 0; i < REG_COUNT; i++)
            plane_shadow[i] = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        rx_mode    = RX_CHOPPY;
        tx_gap_max = 3;
        test_after_reset();
        test_register_index();
        test_plane_boundaries();
        test_random_frustums();

        drain_spheres();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_frustum_sphere_cull: PASS");
        else
            $display("tb_frustum_sphere_cull: FAIL");
        $finish;
    end

endmodule
